@@ hw/rtl/mrhf_pkg.sv @@
package mrhf_pkg;

    localparam int BODY_BYTES  = 6;
    localparam int FRAME_BYTES = 8;
    localparam int BODY_W      = BODY_BYTES * 8;
    localparam int CHAR_IDX_W  = $clog2(FRAME_BYTES * 2);
    localparam int BYTE_IDX_W  = $clog2(FRAME_BYTES);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [7:0]  FUNC_CODE_RESET = 8'd3;
    localparam logic [CHAR_IDX_W-1:0] LAST_CHAR_IDX = CHAR_IDX_W'(FRAME_BYTES * 2 - 1);

    localparam logic [6:0] ASCII_ZERO   = 7'd48;
    localparam logic [6:0] ASCII_A_BASE = 7'd55;

    typedef struct packed {
        logic [BODY_W-1:0] body;
        logic [15:0]       crc;
    } frame_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic logic [6:0] nib_char(input logic [3:0] n);
        logic [6:0] ch;
        if (n <= 4'd9) begin
            ch = ASCII_ZERO + {3'b000, n};
        end else begin
            ch = ASCII_A_BASE + {3'b000, n};
        end
        return ch;
    endfunction

endpackage

@@ hw/rtl/mrhf_crc_stage.sv @@
module mrhf_crc_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  mrhf_pkg::frame_t in_frame,
    input  logic [7:0]      in_byte,
    output logic            out_valid,
    input  logic            out_ready,
    output mrhf_pkg::frame_t out_frame
);

    logic             valid_reg;
    logic             valid_next;
    mrhf_pkg::frame_t frame_reg;
    mrhf_pkg::frame_t frame_next;
    logic             load;

    assign in_ready  = !valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_frame = frame_reg;

    always_comb begin
        valid_next = valid_reg;
        frame_next = frame_reg;
        if (load) begin
            valid_next      = 1'b1;
            frame_next.body = in_frame.body;
            frame_next.crc  = mrhf_pkg::crc_byte(in_frame.crc, in_byte);
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        frame_reg <= frame_next;
    end

endmodule

@@ hw/rtl/mrhf_serializer.sv @@
module mrhf_serializer (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  mrhf_pkg::frame_t in_frame,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [6:0]       out_char,
    output logic             out_last
);

    logic                              busy_reg;
    logic                              busy_next;
    logic [mrhf_pkg::CHAR_IDX_W-1:0]   idx_reg;
    logic [mrhf_pkg::CHAR_IDX_W-1:0]   idx_next;
    logic [7:0]                        byte_reg [mrhf_pkg::FRAME_BYTES];
    logic                              m_valid_reg;
    logic                              m_valid_next;
    logic [6:0]                        m_char_reg;
    logic [6:0]                        m_char_next;
    logic                              m_last_reg;
    logic                              m_last_next;
    logic                              out_free;
    logic                              emit;
    logic                              load;
    logic                              at_last;
    logic [7:0]                        cur_byte;
    logic [3:0]                        cur_nib;

    assign out_free = !m_valid_reg || out_ready;
    assign emit     = busy_reg && out_free;
    assign at_last  = (idx_reg == mrhf_pkg::LAST_CHAR_IDX);
    assign in_ready = !busy_reg || (emit && at_last);
    assign load     = in_valid && in_ready;
    assign cur_byte = byte_reg[idx_reg[mrhf_pkg::CHAR_IDX_W-1:1]];
    assign cur_nib  = idx_reg[0] ? cur_byte[3:0] : cur_byte[7:4];

    always_comb begin
        busy_next    = busy_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_char_next  = mrhf_pkg::nib_char(cur_nib);
            m_last_next  = at_last;
            idx_next     = idx_reg + 1'b1;
            if (at_last) begin
                busy_next = 1'b0;
            end
        end else if (out_ready) begin
            m_valid_next = 1'b0;
        end
        if (load) begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
        if (load) begin
            for (int b = 0; b < mrhf_pkg::BODY_BYTES; b++) begin
                byte_reg[b] <= in_frame.body[b*8 +: 8];
            end
            byte_reg[mrhf_pkg::BODY_BYTES]     <= in_frame.crc[7:0];
            byte_reg[mrhf_pkg::BODY_BYTES + 1] <= in_frame.crc[15:8];
        end
    end

    assign out_valid = m_valid_reg;
    assign out_char  = m_char_reg;
    assign out_last  = m_last_reg;

endmodule

@@ hw/rtl/modbus_read_request_hex_framer.sv @@
// Modbus RTU read request framer with hexadecimal ASCII output.
// Slave stream (s_*): one transaction per request, tdata carries slave address,
// start register and register count. Master stream (m_*): one ASCII hex digit
// per transaction, tlast on the sixteenth digit of each frame.
// Frame: address, function code, start hi/lo, count hi/lo, CRC16 lo/hi;
// each byte goes out high nibble first as '0'-'9' / 'A'-'F'.
// cfg_wen/cfg_wdata write the function code (reset value 3); write only
// while no request is in flight.
// Six CRC stages each fold one byte; a serializer then sends one digit a cycle
// while m_tready is high. Throughput is set by the single-digit output channel,
// which sends the sixteen digits of each request one by one.
// Up to six further requests wait in the CRC stages while a frame is being sent.
// Reset (aresetn low, synchronous) empties all stages and the output register
// and restores the function code.
// When m_tready is low, the output holds its digit and the pipeline backs up
// stage by stage; s_tready drops once every stage is full. Nothing is lost.
module modbus_read_request_hex_framer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic [7:0]  cfg_wdata,   // func_code
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,     // slave_addr[7:0], first_reg[23:8], reg_count[39:24]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,     // ascii_char[6:0], zero[7]
    output logic        m_tlast
);

    localparam int NSTG = mrhf_pkg::BODY_BYTES;

    logic [7:0]       func_code_reg;
    logic [7:0]       func_code_next;
    logic             stg_valid [NSTG+1];
    logic             stg_ready [NSTG+1];
    mrhf_pkg::frame_t stg_frame [NSTG+1];
    logic [6:0]       m_char;

    always_comb begin
        func_code_next = cfg_wen ? cfg_wdata : func_code_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            func_code_reg <= mrhf_pkg::FUNC_CODE_RESET;
        end else begin
            func_code_reg <= func_code_next;
        end
    end

    assign stg_valid[0]      = s_tvalid;
    assign s_tready          = stg_ready[0];
    assign stg_frame[0].body = {s_tdata[31:24], s_tdata[39:32], s_tdata[15:8],
                                s_tdata[23:16], func_code_reg, s_tdata[7:0]};
    assign stg_frame[0].crc  = mrhf_pkg::CRC_INIT;

    for (genvar k = 0; k < NSTG; k++) begin : g_stage
        mrhf_crc_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stg_valid[k]),
            .in_ready  (stg_ready[k]),
            .in_frame  (stg_frame[k]),
            .in_byte   (stg_frame[k].body[k*8 +: 8]),
            .out_valid (stg_valid[k+1]),
            .out_ready (stg_ready[k+1]),
            .out_frame (stg_frame[k+1])
        );
    end

    mrhf_serializer u_ser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (stg_valid[NSTG]),
        .in_ready  (stg_ready[NSTG]),
        .in_frame  (stg_frame[NSTG]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (m_char),
        .out_last  (m_tlast)
    );

    assign m_tdata = {1'b0, m_char};

    a_cfg_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wen |=> func_code_reg == $past(cfg_wdata))
        else $error("function code not taken from cfg write");

    a_hex_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata >= 8'd48 && m_tdata <= 8'd57) ||
                      (m_tdata >= 8'd65 && m_tdata <= 8'd70)))
        else $error("output is not an upper-case hex digit");

    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        stg_valid[NSTG] && !stg_ready[NSTG] |=>
            stg_valid[NSTG] && $stable(stg_frame[NSTG]))
        else $error("last CRC stage dropped or changed a stalled frame");

endmodule
